[hw/rtl/cfcs_pkg.sv]
// Package for the control-flow bus-cycle sequencer.
// Payload types, instruction codes and bus request codes.
// No dependencies.
package cfcs_pkg;

	typedef logic [4:0]  op_t;
	typedef logic [2:0]  req_t;
	typedef logic [23:0] addr24_t;
	typedef logic [15:0] addr16_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  step_t;

	// instruction codes
	localparam op_t OP_BRA    = 5'd0;
	localparam op_t OP_BCC    = 5'd1;
	localparam op_t OP_BCS    = 5'd2;
	localparam op_t OP_BNE    = 5'd3;
	localparam op_t OP_BEQ    = 5'd4;
	localparam op_t OP_BPL    = 5'd5;
	localparam op_t OP_BMI    = 5'd6;
	localparam op_t OP_BVC    = 5'd7;
	localparam op_t OP_BVS    = 5'd8;
	localparam op_t OP_BRL    = 5'd9;
	localparam op_t OP_JMP    = 5'd10;
	localparam op_t OP_JML    = 5'd11;
	localparam op_t OP_JMP_IND  = 5'd12;
	localparam op_t OP_JMP_INDX = 5'd13;
	localparam op_t OP_JML_IND  = 5'd14;
	localparam op_t OP_JSR    = 5'd15;
	localparam op_t OP_JSL    = 5'd16;
	localparam op_t OP_JSR_INDX = 5'd17;
	localparam op_t OP_RTI    = 5'd18;
	localparam op_t OP_RTS    = 5'd19;
	localparam op_t OP_RTL    = 5'd20;

	// bus request codes
	localparam req_t REQ_OPERAND = 3'd0;
	localparam req_t REQ_DATA    = 3'd1;
	localparam req_t REQ_PROGRAM = 3'd2;
	localparam req_t REQ_PUSH    = 3'd3;
	localparam req_t REQ_PULL    = 3'd4;
	localparam req_t REQ_IO      = 3'd5;
	localparam req_t REQ_DONE    = 3'd6;

	// m and x flags forced set by rti in emulation mode
	localparam byte_t RTI_EMU_FORCE = 8'h30;

endpackage

[hw/rtl/cfcs_cmd_if.sv]
// Command channel of the sequencer: one bus cycle worth of inputs.
// Depends on cfcs_pkg.
interface cfcs_cmd_if;
	logic                 valid;
	logic                 ready;
	cfcs_pkg::op_t        op;
	logic                 start_req;
	cfcs_pkg::addr24_t    pc_in;
	cfcs_pkg::byte_t      read_data;
	cfcs_pkg::byte_t      status_in;
	logic                 emulation;
	cfcs_pkg::addr16_t    index_x;

	modport source (output valid, op, start_req, pc_in, read_data, status_in, emulation,
		index_x, input ready);
	modport sink (input valid, op, start_req, pc_in, read_data, status_in, emulation,
		index_x, output ready);
endinterface

[hw/rtl/cfcs_rsp_if.sv]
// Response channel of the sequencer: the next bus request.
// Depends on cfcs_pkg.
interface cfcs_rsp_if;
	logic                 valid;
	logic                 ready;
	cfcs_pkg::req_t       request;
	cfcs_pkg::addr16_t    bus_address;
	cfcs_pkg::byte_t      write_data;
	cfcs_pkg::addr24_t    pc_out;
	cfcs_pkg::byte_t      status_out;
	logic                 clear_index_high;
	logic                 last;

	modport source (output valid, request, bus_address, write_data, pc_out, status_out,
		clear_index_high, last, input ready);
	modport sink (input valid, request, bus_address, write_data, pc_out, status_out,
		clear_index_high, last, output ready);
endinterface

[hw/rtl/cpu_flow_control_sequencer.sv]
// Registered output: a command accepted at a clock edge is the valid response just after it.
// Throughput: one command transaction per clock; the response register frees itself when
// the response is taken in the same cycle; input stalls only if one is held and not taken.
// Each cycle is one pass of decode, 16-bit adds and byte muxing into the response register.
// Reset (arst_n low, asynchronous): sequencer idle, counter and latches zero, no response.
// Depends on cfcs_pkg, cfcs_cmd_if, cfcs_rsp_if.
module cpu_flow_control_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	cfcs_cmd_if.sink    cmd,
	cfcs_rsp_if.source  rsp
);

	// architectural state
	cfcs_pkg::addr24_t pc_q;
	cfcs_pkg::step_t   step_q;      // 0 = idle, else responses issued so far
	cfcs_pkg::op_t     op_q;
	cfcs_pkg::addr24_t al_q;        // indirect / target address latch
	cfcs_pkg::addr24_t dl_q;        // fetched target / pulled return address
	cfcs_pkg::byte_t   rs_q;        // status pulled by rti

	// response register
	logic              rsp_valid_q;
	cfcs_pkg::req_t    req_q;
	cfcs_pkg::addr16_t addr_q;
	cfcs_pkg::byte_t   wd_q;
	cfcs_pkg::addr24_t pc_out_q;
	cfcs_pkg::byte_t   stat_q;
	logic              cih_q;
	logic              last_q;

	logic              accept;
	logic              start;
	logic              active;
	cfcs_pkg::op_t     cur_op;
	cfcs_pkg::step_t   s;
	cfcs_pkg::addr24_t pc;
	cfcs_pkg::byte_t   d;
	cfcs_pkg::addr16_t aw;
	logic              taken;
	logic              rti_restored;

	// next-state / response values
	cfcs_pkg::req_t    req;
	cfcs_pkg::addr16_t addr;
	cfcs_pkg::byte_t   wd;
	logic              lst;
	cfcs_pkg::addr24_t n_pc;
	cfcs_pkg::step_t   n_step;
	cfcs_pkg::addr24_t n_al;
	cfcs_pkg::addr24_t n_dl;
	cfcs_pkg::byte_t   n_rs;

	function automatic cfcs_pkg::addr24_t put_byte(cfcs_pkg::addr24_t l, logic [1:0] idx,
		cfcs_pkg::byte_t v);
		cfcs_pkg::addr24_t r;
		r = l;
		case (idx)
			2'd0: r[7:0]   = v;
			2'd1: r[15:8]  = v;
			2'd2: r[23:16] = v;
			default: r = l;
		endcase
		return r;
	endfunction

	// one response register in front of the sink; taking it frees the slot at once
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	// a start abandons whatever runs and restarts at step 0 with a zero data byte
	assign start  = cmd.start_req;
	assign active = start || (step_q != 3'd0);
	assign cur_op = start ? cmd.op : op_q;
	assign s      = start ? 3'd0 : step_q;
	assign pc     = start ? cmd.pc_in : pc_q;
	assign d      = start ? 8'd0 : cmd.read_data;
	assign aw     = al_q[15:0];

	// branch condition from the status flags of this bus cycle
	always_comb begin
		case (cur_op)
			cfcs_pkg::OP_BRA: taken = 1'b1;
			cfcs_pkg::OP_BCC: taken = !cmd.status_in[0];
			cfcs_pkg::OP_BCS: taken = cmd.status_in[0];
			cfcs_pkg::OP_BNE: taken = !cmd.status_in[1];
			cfcs_pkg::OP_BEQ: taken = cmd.status_in[1];
			cfcs_pkg::OP_BPL: taken = !cmd.status_in[7];
			cfcs_pkg::OP_BMI: taken = cmd.status_in[7];
			cfcs_pkg::OP_BVC: taken = !cmd.status_in[6];
			default:          taken = cmd.status_in[6];
		endcase
	end

	// rti reports its pulled status from the cycle the status byte arrives on
	assign rti_restored = !start && (step_q != 3'd0) && (op_q == cfcs_pkg::OP_RTI) &&
		(step_q >= 3'd3);

	always_comb begin
		req    = cfcs_pkg::REQ_DONE;
		addr   = '0;
		wd     = '0;
		lst    = 1'b0;
		n_pc   = pc;
		n_step = s + 3'd1;
		n_al   = al_q;
		n_dl   = dl_q;
		n_rs   = rs_q;

		if (!active) begin
			// idle continue: nothing running, report done without last
			n_step = 3'd0;
		end else begin
			case (cur_op)
				cfcs_pkg::OP_BRA, cfcs_pkg::OP_BCC, cfcs_pkg::OP_BCS, cfcs_pkg::OP_BNE,
				cfcs_pkg::OP_BEQ, cfcs_pkg::OP_BPL, cfcs_pkg::OP_BMI, cfcs_pkg::OP_BVC,
				cfcs_pkg::OP_BVS: begin
					if (s == 3'd0) begin
						req  = cfcs_pkg::REQ_OPERAND;
						addr = pc[15:0];
						n_pc = {pc[23:16], pc[15:0] + 16'd1};
					end else if (s == 3'd1 && taken) begin
						n_dl = put_byte(dl_q, 2'd0, d);
						n_pc = {pc[23:16], pc[15:0] + {{8{d[7]}}, d}};
						req  = cfcs_pkg::REQ_IO;
					end else begin
						lst = 1'b1;
					end
				end
				cfcs_pkg::OP_BRL: begin
					case (s)
						3'd0, 3'd1: begin
							if (s == 3'd1)
								n_dl = put_byte(dl_q, 2'd0, d);
							req  = cfcs_pkg::REQ_OPERAND;
							addr = pc[15:0];
							n_pc = {pc[23:16], pc[15:0] + 16'd1};
						end
						3'd2: begin
							n_dl = put_byte(dl_q, 2'd1, d);
							n_pc = {pc[23:16], pc[15:0] + {d, dl_q[7:0]}};
							req  = cfcs_pkg::REQ_IO;
						end
						default: lst = 1'b1;
					endcase
				end
				cfcs_pkg::OP_JMP, cfcs_pkg::OP_JML: begin
					if (s == 3'd0 || s == 3'd1 ||
						(s == 3'd2 && cur_op == cfcs_pkg::OP_JML)) begin
						if (s != 3'd0)
							n_dl = put_byte(dl_q, s[1:0] - 2'd1, d);
						req  = cfcs_pkg::REQ_OPERAND;
						addr = pc[15:0];
						n_pc = {pc[23:16], pc[15:0] + 16'd1};
					end else if (s == 3'd2) begin
						n_dl = put_byte(dl_q, 2'd1, d);
						n_pc = {pc[23:16], n_dl[15:0]};
						lst  = 1'b1;
					end else begin
						n_dl = put_byte(dl_q, 2'd2, d);
						n_pc = n_dl;
						lst  = 1'b1;
					end
				end
				cfcs_pkg::OP_JMP_IND, cfcs_pkg::OP_JML_IND: begin
					if (s == 3'd0 || s == 3'd1) begin
						if (s == 3'd1)
							n_al = put_byte(al_q, 2'd0, d);
						req  = cfcs_pkg::REQ_OPERAND;
						addr = pc[15:0];
						n_pc = {pc[23:16], pc[15:0] + 16'd1};
					end else if (s == 3'd2) begin
						n_al = put_byte(al_q, 2'd1, d);
						req  = cfcs_pkg::REQ_DATA;
						addr = n_al[15:0];
					end else if (s == 3'd3) begin
						n_dl = put_byte(dl_q, 2'd0, d);
						req  = cfcs_pkg::REQ_DATA;
						addr = aw + 16'd1;
					end else if (s == 3'd4 && cur_op == cfcs_pkg::OP_JML_IND) begin
						n_dl = put_byte(dl_q, 2'd1, d);
						req  = cfcs_pkg::REQ_DATA;
						addr = aw + 16'd2;
					end else if (s == 3'd4) begin
						n_dl = put_byte(dl_q, 2'd1, d);
						n_pc = {pc[23:16], n_dl[15:0]};
						lst  = 1'b1;
					end else begin
						n_dl = put_byte(dl_q, 2'd2, d);
						n_pc = n_dl;
						lst  = 1'b1;
					end
				end
				cfcs_pkg::OP_JMP_INDX: begin
					case (s)
						3'd0, 3'd1: begin
							if (s == 3'd1)
								n_al = put_byte(al_q, 2'd0, d);
							req  = cfcs_pkg::REQ_OPERAND;
							addr = pc[15:0];
							n_pc = {pc[23:16], pc[15:0] + 16'd1};
						end
						3'd2: begin
							n_al = put_byte(al_q, 2'd1, d);
							req  = cfcs_pkg::REQ_IO;
						end
						3'd3: begin
							req  = cfcs_pkg::REQ_PROGRAM;
							addr = aw + cmd.index_x;
						end
						3'd4: begin
							n_dl = put_byte(dl_q, 2'd0, d);
							req  = cfcs_pkg::REQ_PROGRAM;
							addr = aw + cmd.index_x + 16'd1;
						end
						default: begin
							n_dl = put_byte(dl_q, 2'd1, d);
							n_pc = {pc[23:16], n_dl[15:0]};
							lst  = 1'b1;
						end
					endcase
				end
				cfcs_pkg::OP_JSR: begin
					case (s)
						3'd0, 3'd1: begin
							if (s == 3'd1)
								n_al = put_byte(al_q, 2'd0, d);
							req  = cfcs_pkg::REQ_OPERAND;
							addr = pc[15:0];
							n_pc = {pc[23:16], pc[15:0] + 16'd1};
						end
						3'd2: begin
							n_al = put_byte(al_q, 2'd1, d);
							req  = cfcs_pkg::REQ_IO;
						end
						3'd3: begin
							// push return address minus one, high byte first
							n_pc = {pc[23:16], pc[15:0] - 16'd1};
							req  = cfcs_pkg::REQ_PUSH;
							wd   = n_pc[15:8];
						end
						3'd4: begin
							req  = cfcs_pkg::REQ_PUSH;
							wd   = pc[7:0];
							n_pc = {pc[23:16], al_q[15:0]};
						end
						default: lst = 1'b1;
					endcase
				end
				cfcs_pkg::OP_JSL: begin
					case (s)
						3'd0, 3'd1, 3'd4: begin
							if (s == 3'd1)
								n_al = put_byte(al_q, 2'd0, d);
							req  = cfcs_pkg::REQ_OPERAND;
							addr = pc[15:0];
							n_pc = {pc[23:16], pc[15:0] + 16'd1};
						end
						3'd2: begin
							n_al = put_byte(al_q, 2'd1, d);
							req  = cfcs_pkg::REQ_PUSH;
							wd   = pc[23:16];
						end
						3'd3: req = cfcs_pkg::REQ_IO;
						3'd5: begin
							n_al = put_byte(al_q, 2'd2, d);
							n_pc = {pc[23:16], pc[15:0] - 16'd1};
							req  = cfcs_pkg::REQ_PUSH;
							wd   = n_pc[15:8];
						end
						3'd6: begin
							req  = cfcs_pkg::REQ_PUSH;
							wd   = pc[7:0];
							n_pc = al_q;
						end
						default: lst = 1'b1;
					endcase
				end
				cfcs_pkg::OP_JSR_INDX: begin
					case (s)
						3'd0, 3'd3: begin
							req  = cfcs_pkg::REQ_OPERAND;
							addr = pc[15:0];
							n_pc = {pc[23:16], pc[15:0] + 16'd1};
						end
						3'd1: begin
							n_al = put_byte(al_q, 2'd0, d);
							req  = cfcs_pkg::REQ_PUSH;
							wd   = pc[15:8];
						end
						3'd2: begin
							req  = cfcs_pkg::REQ_PUSH;
							wd   = pc[7:0];
						end
						3'd4: begin
							n_al = put_byte(al_q, 2'd1, d);
							req  = cfcs_pkg::REQ_IO;
						end
						3'd5: begin
							req  = cfcs_pkg::REQ_PROGRAM;
							addr = aw + cmd.index_x;
						end
						3'd6: begin
							n_dl = put_byte(dl_q, 2'd0, d);
							req  = cfcs_pkg::REQ_PROGRAM;
							addr = aw + cmd.index_x + 16'd1;
						end
						default: begin
							n_dl = put_byte(dl_q, 2'd1, d);
							n_pc = {pc[23:16], n_dl[15:0]};
							lst  = 1'b1;
						end
					endcase
				end
				cfcs_pkg::OP_RTI, cfcs_pkg::OP_RTS, cfcs_pkg::OP_RTL: begin
					if (s <= 3'd1) begin
						req = cfcs_pkg::REQ_IO;
					end else if (s == 3'd2) begin
						req = cfcs_pkg::REQ_PULL;
					end else if (cur_op == cfcs_pkg::OP_RTI && s == 3'd3) begin
						n_rs = d | (cmd.emulation ? cfcs_pkg::RTI_EMU_FORCE : 8'h00);
						req  = cfcs_pkg::REQ_PULL;
					end else if (s == 3'd3 || (cur_op == cfcs_pkg::OP_RTI && s == 3'd4)) begin
						n_dl = put_byte(dl_q, 2'd0, d);
						req  = cfcs_pkg::REQ_PULL;
					end else if (cur_op == cfcs_pkg::OP_RTS) begin
						if (s == 3'd4) begin
							n_dl = put_byte(dl_q, 2'd1, d);
							n_pc = {pc[23:16], n_dl[15:0] + 16'd1};
							req  = cfcs_pkg::REQ_IO;
						end else begin
							lst = 1'b1;
						end
					end else if (cur_op == cfcs_pkg::OP_RTL) begin
						if (s == 3'd4) begin
							n_dl = put_byte(dl_q, 2'd1, d);
							req  = cfcs_pkg::REQ_PULL;
						end else begin
							n_dl = put_byte(dl_q, 2'd2, d);
							n_pc = {n_dl[23:16], n_dl[15:0] + 16'd1};
							lst  = 1'b1;
						end
					end else if (s == 3'd5) begin
						// rti: emulation mode pulls no bank byte
						n_dl = put_byte(dl_q, 2'd1, d);
						if (cmd.emulation) begin
							n_pc = {pc[23:16], n_dl[15:0]};
							lst  = 1'b1;
						end else begin
							req = cfcs_pkg::REQ_PULL;
						end
					end else begin
						n_dl = put_byte(dl_q, 2'd2, d);
						n_pc = n_dl;
						lst  = 1'b1;
					end
				end
				default: lst = 1'b1;   // unknown codes finish at once
			endcase
			if (lst)
				n_step = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			step_q <= '0;
			op_q   <= '0;
			al_q   <= '0;
			dl_q   <= '0;
			rs_q   <= '0;
		end else if (accept) begin
			pc_q   <= n_pc;
			step_q <= n_step;
			op_q   <= cur_op;
			al_q   <= n_al;
			dl_q   <= n_dl;
			rs_q   <= n_rs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req;
			addr_q   <= addr;
			wd_q     <= wd;
			pc_out_q <= n_pc;
			stat_q   <= rti_restored ? n_rs : cmd.status_in;
			cih_q    <= rti_restored ? n_rs[4] : 1'b0;
			last_q   <= lst;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.request          = req_q;
	assign rsp.bus_address      = addr_q;
	assign rsp.write_data       = wd_q;
	assign rsp.pc_out           = pc_out_q;
	assign rsp.status_out       = stat_q;
	assign rsp.clear_index_high = cih_q;
	assign rsp.last             = last_q;

`ifndef SYNTH
	// a running instruction always has a known code
	a_known_op: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != 3'd0) |-> (op_q <= cfcs_pkg::OP_RTL))
		else $error("sequencer running with unknown op");

	// every accepted command yields a response next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted command without response");

	// a finishing response is a done request and leaves the sequencer idle
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && last_q) |-> (req_q == cfcs_pkg::REQ_DONE && step_q == 3'd0))
		else $error("last response not done or sequencer still busy");

	// index-high clear only comes with a restored x flag
	a_cih_xflag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && cih_q) |-> stat_q[4])
		else $error("index high clear without x flag");
`endif

endmodule

[verif/cpu_flow_control_sequencer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for cpu_flow_control_sequencer: directed table, then random
// instruction sequences; responses checked against typed rows or a cycle-level predictor.
// Depends on cfcs_pkg, cfcs_cmd_if, cfcs_rsp_if and the sequencer RTL.
module cpu_flow_control_sequencer_tb;

	localparam int ITEM_TARGET  = 1900;
	localparam int HOLD_AT      = 1300;   // response side freezes once this many are in
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	// no instruction uses this code; the block must finish it at once
	localparam cfcs_pkg::op_t OP_UNUSED_TOP = 5'd31;

	typedef struct packed {
		cfcs_pkg::op_t     op;
		logic              start_req;
		cfcs_pkg::addr24_t pc_in;
		cfcs_pkg::byte_t   read_data;
		cfcs_pkg::byte_t   status_in;
		logic              emulation;
		cfcs_pkg::addr16_t index_x;
	} cycle_cmd_t;

	typedef struct packed {
		cfcs_pkg::req_t    request;
		cfcs_pkg::addr16_t bus_address;
		cfcs_pkg::byte_t   write_data;
		cfcs_pkg::addr24_t pc_out;
		cfcs_pkg::byte_t   status_out;
		logic              clear_index_high;
		logic              last;
	} bus_req_t;

	// typed = 1: exp is written out by hand, otherwise the predictor supplies it
	typedef struct {
		cycle_cmd_t cmd;
		bit         typed;
		bus_req_t   exp;
	} directed_row_t;

	typedef enum {STALL_NONE, STALL_HALF, STALL_QUARTER, STALL_PATTERN} stall_mode_t;

	logic clk;
	logic arst_n;

	cfcs_cmd_if cmd_ch ();
	cfcs_rsp_if rsp_ch ();

	cpu_flow_control_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: mirrors the sequencer's registers.
	// ------------------------------------------------------------------
	cfcs_pkg::addr24_t seq_pc;
	cfcs_pkg::step_t   seq_step;      // 0 = idle, else bus requests issued so far
	cfcs_pkg::op_t     seq_op;
	cfcs_pkg::addr24_t addr_latch;
	cfcs_pkg::addr24_t data_latch;
	cfcs_pkg::byte_t   rest_status;   // status byte pulled by rti

	bus_req_t pending_bus_reqs[$];

	int items_sent;
	int burst_left;
	int fail_count;
	int responses_checked;
	int instr_count;
	int abandoned;
	int cycle_count;

	function automatic void issue(inout bus_req_t r, input cfcs_pkg::req_t q,
			input cfcs_pkg::addr16_t a, input cfcs_pkg::byte_t w);
		r.request = q;
		r.bus_address = a;
		r.write_data = w;
	endfunction

	// operand read at the counter, counter advances and wraps inside the bank
	function automatic void fetch_operand(inout bus_req_t r);
		issue(r, cfcs_pkg::REQ_OPERAND, seq_pc[15:0], 8'h00);
		seq_pc[15:0] = seq_pc[15:0] + 16'd1;
	endfunction

	function automatic void finish_instr(inout bus_req_t r);
		issue(r, cfcs_pkg::REQ_DONE, 16'h0000, 8'h00);
		r.last = 1'b1;
		seq_step = '0;
	endfunction

	// One bus cycle of the running instruction; s is the step before this cycle.
	function automatic void run_step(input cfcs_pkg::step_t s, input cycle_cmd_t c,
			inout bus_req_t r);
		cfcs_pkg::addr16_t aw;
		cfcs_pkg::byte_t   d;
		bit                go;
		aw = addr_latch[15:0];
		d = c.read_data;
		seq_step = s + 3'd1;
		if (seq_op <= cfcs_pkg::OP_BVS) begin
			case (seq_op)
			cfcs_pkg::OP_BRA: go = 1'b1;
			cfcs_pkg::OP_BCC: go = !c.status_in[0];
			cfcs_pkg::OP_BCS: go = c.status_in[0];
			cfcs_pkg::OP_BNE: go = !c.status_in[1];
			cfcs_pkg::OP_BEQ: go = c.status_in[1];
			cfcs_pkg::OP_BPL: go = !c.status_in[7];
			cfcs_pkg::OP_BMI: go = c.status_in[7];
			cfcs_pkg::OP_BVC: go = !c.status_in[6];
			default: go = c.status_in[6];
			endcase
			if (s == 0) fetch_operand(r);
			else if (s == 1 && go) begin
				data_latch[7:0] = d;
				seq_pc[15:0] = seq_pc[15:0] + {{8{d[7]}}, d};
				issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			end else finish_instr(r);
			return;
		end
		case (seq_op)
		cfcs_pkg::OP_BRL: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				data_latch[7:0] = d;
				fetch_operand(r);
			end else if (s == 2) begin
				data_latch[15:8] = d;
				seq_pc[15:0] = seq_pc[15:0] + data_latch[15:0];
				issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			end else finish_instr(r);
		end
		cfcs_pkg::OP_JMP, cfcs_pkg::OP_JML: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				data_latch[7:0] = d;
				fetch_operand(r);
			end else if (s == 2 && seq_op == cfcs_pkg::OP_JML) begin
				data_latch[15:8] = d;
				fetch_operand(r);
			end else if (s == 2) begin
				data_latch[15:8] = d;
				seq_pc[15:0] = data_latch[15:0];
				finish_instr(r);
			end else begin
				data_latch[23:16] = d;
				seq_pc = data_latch;
				finish_instr(r);
			end
		end
		cfcs_pkg::OP_JMP_IND, cfcs_pkg::OP_JML_IND: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				addr_latch[7:0] = d;
				fetch_operand(r);
			end else if (s == 2) begin
				addr_latch[15:8] = d;
				issue(r, cfcs_pkg::REQ_DATA, addr_latch[15:0], 8'h00);
			end else if (s == 3) begin
				data_latch[7:0] = d;
				issue(r, cfcs_pkg::REQ_DATA, aw + 16'd1, 8'h00);
			end else if (s == 4 && seq_op == cfcs_pkg::OP_JML_IND) begin
				data_latch[15:8] = d;
				issue(r, cfcs_pkg::REQ_DATA, aw + 16'd2, 8'h00);
			end else if (s == 4) begin
				data_latch[15:8] = d;
				seq_pc[15:0] = data_latch[15:0];
				finish_instr(r);
			end else begin
				data_latch[23:16] = d;
				seq_pc = data_latch;
				finish_instr(r);
			end
		end
		cfcs_pkg::OP_JMP_INDX: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				addr_latch[7:0] = d;
				fetch_operand(r);
			end else if (s == 2) begin
				addr_latch[15:8] = d;
				issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			end else if (s == 3) issue(r, cfcs_pkg::REQ_PROGRAM, aw + c.index_x, 8'h00);
			else if (s == 4) begin
				data_latch[7:0] = d;
				issue(r, cfcs_pkg::REQ_PROGRAM, aw + c.index_x + 16'd1, 8'h00);
			end else begin
				data_latch[15:8] = d;
				seq_pc[15:0] = data_latch[15:0];
				finish_instr(r);
			end
		end
		cfcs_pkg::OP_JSR: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				addr_latch[7:0] = d;
				fetch_operand(r);
			end else if (s == 2) begin
				addr_latch[15:8] = d;
				issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			end else if (s == 3) begin
				seq_pc[15:0] = seq_pc[15:0] - 16'd1;
				issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[15:8]);
			end else if (s == 4) begin
				issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[7:0]);
				seq_pc[15:0] = addr_latch[15:0];
			end else finish_instr(r);
		end
		cfcs_pkg::OP_JSL: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				addr_latch[7:0] = d;
				fetch_operand(r);
			end else if (s == 2) begin
				addr_latch[15:8] = d;
				issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[23:16]);
			end else if (s == 3) issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			else if (s == 4) fetch_operand(r);
			else if (s == 5) begin
				addr_latch[23:16] = d;
				seq_pc[15:0] = seq_pc[15:0] - 16'd1;
				issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[15:8]);
			end else if (s == 6) begin
				issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[7:0]);
				seq_pc = addr_latch;
			end else finish_instr(r);
		end
		cfcs_pkg::OP_JSR_INDX: begin
			if (s == 0) fetch_operand(r);
			else if (s == 1) begin
				addr_latch[7:0] = d;
				issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[15:8]);
			end else if (s == 2) issue(r, cfcs_pkg::REQ_PUSH, 16'h0000, seq_pc[7:0]);
			else if (s == 3) fetch_operand(r);
			else if (s == 4) begin
				addr_latch[15:8] = d;
				issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			end else if (s == 5) issue(r, cfcs_pkg::REQ_PROGRAM, aw + c.index_x, 8'h00);
			else if (s == 6) begin
				data_latch[7:0] = d;
				issue(r, cfcs_pkg::REQ_PROGRAM, aw + c.index_x + 16'd1, 8'h00);
			end else begin
				data_latch[15:8] = d;
				seq_pc[15:0] = data_latch[15:0];
				finish_instr(r);
			end
		end
		cfcs_pkg::OP_RTI, cfcs_pkg::OP_RTS, cfcs_pkg::OP_RTL: begin
			if (s <= 1) issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
			else if (s == 2) issue(r, cfcs_pkg::REQ_PULL, 16'h0000, 8'h00);
			else if (seq_op == cfcs_pkg::OP_RTI && s == 3) begin
				// emulation mode forces m and x set
				rest_status = d | (c.emulation ? cfcs_pkg::RTI_EMU_FORCE : 8'h00);
				issue(r, cfcs_pkg::REQ_PULL, 16'h0000, 8'h00);
			end else if (s == 3 || (seq_op == cfcs_pkg::OP_RTI && s == 4)) begin
				data_latch[7:0] = d;
				issue(r, cfcs_pkg::REQ_PULL, 16'h0000, 8'h00);
			end else if (seq_op == cfcs_pkg::OP_RTS) begin
				if (s == 4) begin
					data_latch[15:8] = d;
					seq_pc[15:0] = data_latch[15:0] + 16'd1;
					issue(r, cfcs_pkg::REQ_IO, 16'h0000, 8'h00);
				end else finish_instr(r);
			end else if (seq_op == cfcs_pkg::OP_RTL) begin
				if (s == 4) begin
					data_latch[15:8] = d;
					issue(r, cfcs_pkg::REQ_PULL, 16'h0000, 8'h00);
				end else begin
					data_latch[23:16] = d;
					seq_pc = data_latch;
					seq_pc[15:0] = seq_pc[15:0] + 16'd1;
					finish_instr(r);
				end
			end else if (s == 5) begin
				data_latch[15:8] = d;
				// no bank byte in emulation mode
				if (c.emulation) begin
					seq_pc[15:0] = data_latch[15:0];
					finish_instr(r);
				end else issue(r, cfcs_pkg::REQ_PULL, 16'h0000, 8'h00);
			end else begin
				data_latch[23:16] = d;
				seq_pc = data_latch;
				finish_instr(r);
			end
		end
		default: finish_instr(r);
		endcase
	endfunction

	// Expected response for one accepted command transaction; updates predictor state.
	function automatic bus_req_t predict_bus_cycle(input cycle_cmd_t c);
		bus_req_t r;
		logic     restored;
		r = '0;
		r.request = cfcs_pkg::REQ_DONE;
		restored = 1'b0;
		if (c.start_req) begin
			// a start always wins, abandoning whatever was running
			seq_op = c.op;
			seq_pc = c.pc_in;
			seq_step = '0;
			run_step(3'd0, c, r);
		end else if (seq_step != 0) begin
			restored = (seq_op == cfcs_pkg::OP_RTI && seq_step >= 3);
			run_step(seq_step, c, r);
		end
		r.pc_out = seq_pc;
		r.status_out = restored ? rest_status : c.status_in;
		r.clear_index_high = restored & rest_status[4];
		return r;
	endfunction

	function automatic cycle_cmd_t random_bus_cycle(input bit start, input cfcs_pkg::op_t op,
			input cfcs_pkg::addr24_t pc, input bit emu);
		cycle_cmd_t c;
		c.op = op;
		c.start_req = start;
		c.pc_in = pc;
		c.read_data = cfcs_pkg::byte_t'($urandom);
		c.status_in = cfcs_pkg::byte_t'($urandom);
		c.emulation = emu;
		case ($urandom_range(0, 6))
		0: c.index_x = 16'hFFFF;
		1: c.index_x = 16'h0000;
		default: c.index_x = cfcs_pkg::addr16_t'($urandom);
		endcase
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Command side: bursts of random length separated by random gaps.
	// Valid stays high from one transaction to the next inside a burst.
	// ------------------------------------------------------------------
	task automatic send_bus_cycle(input cycle_cmd_t c, input bit typed = 1'b0,
			input bus_req_t typed_rsp = '0);
		bus_req_t predicted;
		int       gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 16);
		end
		burst_left--;
		cmd_ch.valid     <= 1'b1;
		cmd_ch.op        <= c.op;
		cmd_ch.start_req <= c.start_req;
		cmd_ch.pc_in     <= c.pc_in;
		cmd_ch.read_data <= c.read_data;
		cmd_ch.status_in <= c.status_in;
		cmd_ch.emulation <= c.emulation;
		cmd_ch.index_x   <= c.index_x;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = predict_bus_cycle(c);
		pending_bus_reqs.push_back(typed ? typed_rsp : predicted);
		items_sent++;
	endtask

	// ------------------------------------------------------------------
	// Response side: ready follows a changing stall mode, plus one long
	// hold-off so the response register backs up into the command side.
	// ------------------------------------------------------------------
	initial begin : rsp_throttle
		stall_mode_t mode;
		int          mode_left;
		logic [7:0]  pattern;
		bit          held;
		rsp_ch.ready = 1'b0;
		mode = STALL_NONE;
		mode_left = 50;
		pattern = 8'b1011_0110;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && items_sent >= HOLD_AT) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case (mode)
				STALL_NONE:    rsp_ch.ready <= 1'b1;
				STALL_HALF:    rsp_ch.ready <= 1'($urandom_range(0, 1));
				STALL_QUARTER: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				default: begin
					rsp_ch.ready <= pattern[0];
					pattern = {pattern[0], pattern[7:1]};
				end
				endcase
				mode_left--;
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response checker: every response transaction against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		bus_req_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_bus_reqs.size() == 0) begin
				$error("response with no transaction outstanding");
				fail_count++;
			end else begin
				want = pending_bus_reqs.pop_front();
				responses_checked++;
				check_field("request", want.request, rsp_ch.request);
				check_field("bus_address", want.bus_address, rsp_ch.bus_address);
				check_field("write_data", want.write_data, rsp_ch.write_data);
				check_field("pc_out", want.pc_out, rsp_ch.pc_out);
				check_field("status_out", want.status_out, rsp_ch.status_out);
				check_field("clear_index_high", want.clear_index_high,
					rsp_ch.clear_index_high);
				check_field("last", want.last, rsp_ch.last);
			end
		end
	end

	// Watchdog: a hang or a lost response ends here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d responses outstanding", CYCLE_LIMIT,
			pending_bus_reqs.size());
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		directed_row_t     rows[$];
		cfcs_pkg::op_t     op;
		cfcs_pkg::addr24_t pc;
		bit                emu;
		bit                drained;

		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = cfcs_pkg::OP_BRA;
		cmd_ch.start_req = 1'b0;
		cmd_ch.pc_in = '0;
		cmd_ch.read_data = '0;
		cmd_ch.status_in = '0;
		cmd_ch.emulation = 1'b0;
		cmd_ch.index_x = '0;
		seq_pc = '0;
		seq_step = '0;
		seq_op = cfcs_pkg::OP_BRA;
		addr_latch = '0;
		data_latch = '0;
		rest_status = '0;
		items_sent = 0;
		burst_left = 0;
		fail_count = 0;
		responses_checked = 0;
		instr_count = 0;
		abandoned = 0;
		drained = 1'b0;

		// continue with nothing running: done, last low, counter untouched
		rows.push_back('{'{cfcs_pkg::OP_BRA, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b0, 16'h0000},
			1'b1, '{cfcs_pkg::REQ_DONE, 16'h0000, 8'h00, 24'h000000, 8'h00, 1'b0, 1'b0}});
		// bra from the top of memory: operand fetch wraps within the bank
		rows.push_back('{'{cfcs_pkg::OP_BRA, 1'b1, 24'hFFFFFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF},
			1'b1, '{cfcs_pkg::REQ_OPERAND, 16'hFFFF, 8'h00, 24'hFF0000, 8'hFF, 1'b0, 1'b0}});
		// most negative displacement, wraps back into the top of the bank
		rows.push_back('{'{cfcs_pkg::OP_BRA, 1'b0, 24'h000000, 8'h80, 8'hFF, 1'b1, 16'hFFFF},
			1'b1, '{cfcs_pkg::REQ_IO, 16'h0000, 8'h00, 24'hFFFF80, 8'hFF, 1'b0, 1'b0}});
		rows.push_back('{'{cfcs_pkg::OP_BRA, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b0, 16'h0000},
			1'b1, '{cfcs_pkg::REQ_DONE, 16'h0000, 8'h00, 24'hFFFF80, 8'h00, 1'b0, 1'b1}});
		// back-to-back starts of all but bra and rti, each after the first cutting the last short
		for (int o = cfcs_pkg::OP_BCC; o <= cfcs_pkg::OP_RTL; o++) begin
			if (o != cfcs_pkg::OP_RTI)
				rows.push_back('{'{cfcs_pkg::op_t'(o), 1'b1,
					(o % 2) ? {8'(o), 16'hFFFF} : {8'(o), 16'h8000},
					8'h00, (o % 2) ? 8'hFF : 8'h00, o[1], 16'hFFFF}, 1'b0, '0});
		end
		// rti in emulation mode: m/x forced on, no bank pull
		rows.push_back('{'{cfcs_pkg::OP_RTI, 1'b1, 24'hAB0000, 8'h00, 8'h00, 1'b1, 16'h0000},
			1'b0, '0});
		rows.push_back('{'{cfcs_pkg::OP_RTI, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b1, 16'h0000},
			1'b0, '0});
		rows.push_back('{'{cfcs_pkg::OP_RTI, 1'b0, 24'h000000, 8'h00, 8'h00, 1'b1, 16'h0000},
			1'b0, '0});
		rows.push_back('{'{cfcs_pkg::OP_RTI, 1'b0, 24'h000000, 8'h00, 8'hC3, 1'b1, 16'h0000},
			1'b1, '{cfcs_pkg::REQ_PULL, 16'h0000, 8'h00, 24'hAB0000, 8'h30, 1'b1, 1'b0}});
		rows.push_back('{'{cfcs_pkg::OP_RTI, 1'b0, 24'h000000, 8'h34, 8'hC3, 1'b1, 16'h0000},
			1'b0, '0});
		rows.push_back('{'{cfcs_pkg::OP_RTI, 1'b0, 24'h000000, 8'h12, 8'h00, 1'b1, 16'h0000},
			1'b1, '{cfcs_pkg::REQ_DONE, 16'h0000, 8'h00, 24'hAB1234, 8'h30, 1'b1, 1'b1}});
		// unused opcode finishes on the start cycle
		rows.push_back('{'{OP_UNUSED_TOP, 1'b1, 24'hFFFFFF, 8'hFF, 8'h5A, 1'b0, 16'h0000},
			1'b1, '{cfcs_pkg::REQ_DONE, 16'h0000, 8'h00, 24'hFFFFFF, 8'h5A, 1'b0, 1'b1}});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_bus_cycle(rows[i].cmd, rows[i].typed, rows[i].exp);

		// Random part: mostly complete instructions with random operand and stack
		// bytes, some cut short by a new start, some idle continues in between.
		while (items_sent < ITEM_TARGET) begin
			// once: let the block run dry before carrying on
			if (!drained && items_sent >= ITEM_TARGET / 2) begin
				drained = 1'b1;
				cmd_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_bus_reqs.size() != 0);
				burst_left = 1;
			end
			op = ($urandom_range(0, 19) == 0) ? cfcs_pkg::op_t'($urandom_range(21, 31))
				: cfcs_pkg::op_t'($urandom_range(cfcs_pkg::OP_BRA, cfcs_pkg::OP_RTL));
			case ($urandom_range(0, 9))
			0: pc = 24'hFFFFFF;
			1: pc = 24'h000000;
			2: pc = {8'($urandom), 16'hFFFF};
			3: pc = {8'($urandom), 16'hFFFE};
			default: pc = cfcs_pkg::addr24_t'($urandom);
			endcase
			emu = 1'($urandom_range(0, 1));
			instr_count++;
			send_bus_cycle(random_bus_cycle(1'b1, op, pc, emu));
			while (seq_step != 0) begin
				if ($urandom_range(0, 49) == 0) begin
					abandoned++;
					break;
				end
				send_bus_cycle(random_bus_cycle(1'b0, cfcs_pkg::op_t'($urandom),
					cfcs_pkg::addr24_t'($urandom),
					($urandom_range(0, 9) == 0) ? !emu : emu));
			end
			if (seq_step == 0 && $urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3))
					send_bus_cycle(random_bus_cycle(1'b0, cfcs_pkg::op_t'($urandom),
						cfcs_pkg::addr24_t'($urandom), 1'($urandom_range(0, 1))));
		end

		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_bus_reqs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bus cycles: %0d random instructions, %0d cut short by a new start",
			items_sent, instr_count, abandoned);
		$display("Compared %0d responses, %0d field mismatches", responses_checked,
			fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/cfcs_pkg.sv
hw/rtl/cfcs_cmd_if.sv
hw/rtl/cfcs_rsp_if.sv
hw/rtl/cpu_flow_control_sequencer.sv
verif/cpu_flow_control_sequencer_tb.sv
